>>> hdl/okvt_pkg.sv
// ----------------------------------------------------------------------------
// okvt_pkg
// Shared constants, operation and status codes and the cell command type
// for the ordered key/value table.
// ----------------------------------------------------------------------------
package okvt_pkg;

   localparam int CAPACITY   = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int OP_BITS    = 3;
   localparam int POS_BITS   = 4;
   localparam int STAT_BITS  = 2;

   localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_BITS-1:0] OP_UPDATE = 3'd1;
   localparam logic [OP_BITS-1:0] OP_UPSERT = 3'd2;
   localparam logic [OP_BITS-1:0] OP_ERASE  = 3'd3;
   localparam logic [OP_BITS-1:0] OP_LOOKUP = 3'd4;
   localparam logic [OP_BITS-1:0] OP_READ   = 3'd5;

   localparam logic [STAT_BITS-1:0] ST_DONE     = 2'd0;
   localparam logic [STAT_BITS-1:0] ST_MISMATCH = 2'd1;
   localparam logic [STAT_BITS-1:0] ST_FULL     = 2'd2;
   localparam logic [STAT_BITS-1:0] ST_RANGE    = 2'd3;

   typedef struct packed {
      logic take_newer;   // shift one slot older: load from the newer neighbor
      logic take_older;   // close a gap: load from the older neighbor
      logic write_value;  // overwrite the stored value in place
   } cell_cmd_type;

endpackage

>>> hdl/okvt_cell.sv
// ----------------------------------------------------------------------------
// okvt_cell
// One slot of the table: holds a key, a value and a valid bit, compares the
// stored key, and loads from either neighbor when entries shift.
// ----------------------------------------------------------------------------
module okvt_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  okvt_pkg::cell_cmd_type            cmd,
   input  logic [okvt_pkg::KEY_BITS-1:0]     cmp_key,
   input  logic [okvt_pkg::VALUE_BITS-1:0]   wr_value,
   input  logic [okvt_pkg::KEY_BITS-1:0]     newer_key,
   input  logic [okvt_pkg::VALUE_BITS-1:0]   newer_value,
   input  logic                              newer_valid,
   input  logic [okvt_pkg::KEY_BITS-1:0]     older_key,
   input  logic [okvt_pkg::VALUE_BITS-1:0]   older_value,
   input  logic                              older_valid,
   input  logic                              hit_in,
   output logic [okvt_pkg::KEY_BITS-1:0]     key,
   output logic [okvt_pkg::VALUE_BITS-1:0]   value,
   output logic                              valid,
   output logic                              match,
   output logic                              hit_out
);

   logic [okvt_pkg::KEY_BITS-1:0]   key_ff, key_in;
   logic [okvt_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic                            valid_ff, valid_in;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.take_newer) begin
         key_in   = newer_key;
         value_in = newer_value;
         valid_in = newer_valid;
      end else if (cmd.take_older) begin
         key_in   = older_key;
         value_in = older_value;
         valid_in = older_valid;
      end else if (cmd.write_value) begin
         value_in = wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign match   = valid_ff && (key_ff == cmp_key);
   // set in this slot and every older one once the key is found
   assign hit_out = hit_in | match;
   assign key     = key_ff;
   assign value   = value_ff;
   assign valid   = valid_ff;

endmodule

>>> hdl/ordered_key_value_table.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table
// Bounded key/value table kept newest first in a row of slot cells.
// ----------------------------------------------------------------------------
// Usage: drive req_operation, req_key, req_value and req_position and raise
// start; the transaction is taken at a rising edge where start is high and
// busy is low. busy stays high through the working states: in S_COMPARE every
// cell compares its key with the request key at once, in S_APPLY the row
// shifts one slot (insert), closes the gap (erase) or rewrites a value in
// place, and the response is registered. The response appears on the rsp_
// ports for exactly one cycle with rsp_strobe high, once S_APPLY has ended;
// the receiver must take it then, it cannot stall the block.
// A new request is accepted at the edge that ends the response cycle, so the
// block handles one transaction at a time, passing through the compare state,
// the apply state and the idle state in which the response is shown.
// rsp_entry_count gives the live entries after the request. Synchronous
// reset empties the table (all slots invalid, count zero) and drops any
// transaction in flight; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ordered_key_value_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [okvt_pkg::OP_BITS-1:0]        req_operation,
   input  logic [okvt_pkg::KEY_BITS-1:0]       req_key,
   input  logic [okvt_pkg::VALUE_BITS-1:0]     req_value,
   input  logic [okvt_pkg::POS_BITS-1:0]       req_position,
   output logic                                rsp_strobe,
   output logic                                rsp_ok,
   output logic [okvt_pkg::STAT_BITS-1:0]      rsp_status,
   output logic [okvt_pkg::KEY_BITS-1:0]       rsp_found_key,
   output logic [okvt_pkg::VALUE_BITS-1:0]     rsp_found_value,
   output logic [okvt_pkg::COUNT_BITS-1:0]     rsp_entry_count
);

   localparam int CAP = okvt_pkg::CAPACITY;
   localparam int KB  = okvt_pkg::KEY_BITS;
   localparam int VB  = okvt_pkg::VALUE_BITS;
   localparam int CB  = okvt_pkg::COUNT_BITS;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_COMPARE = 2'd1;
   localparam logic [1:0] S_APPLY   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [CB-1:0] count_ff, count_in;

   logic [okvt_pkg::OP_BITS-1:0]  op_ff;
   logic [KB-1:0]                 key_ff;
   logic [VB-1:0]                 value_ff;
   logic [okvt_pkg::POS_BITS-1:0] pos_ff;

   logic [CAP-1:0] match_ff, chain_ff, sel_ff, sel_in;

   logic [KB-1:0] cell_key   [CAP];
   logic [VB-1:0] cell_value [CAP];
   logic [CAP-1:0] cell_valid, cell_match;
   logic [CAP:0]   cell_hit;
   okvt_pkg::cell_cmd_type cell_cmd [CAP];

   logic          rsp_strobe_ff, rsp_ok_ff;
   logic [okvt_pkg::STAT_BITS-1:0] rsp_status_ff;
   logic [KB-1:0] rsp_key_ff;
   logic [VB-1:0] rsp_value_ff;
   logic [CB-1:0] rsp_count_ff;

   logic ok_in;
   logic [okvt_pkg::STAT_BITS-1:0] status_in;
   logic [KB-1:0] fk_in, sel_key;
   logic [VB-1:0] fv_in, sel_value;
   logic do_insert, do_erase, do_write, hit, full, in_range;

   // ---------------------------------------------------------------- cell row
   assign cell_hit[0] = 1'b0;

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic [KB-1:0] nk, ok_k;
      logic [VB-1:0] nv, ov;
      logic          nval, oval;
      if (i == 0) begin : g_head
         assign nk   = key_ff;
         assign nv   = value_ff;
         assign nval = 1'b1;
      end else begin : g_body
         assign nk   = cell_key[i-1];
         assign nv   = cell_value[i-1];
         assign nval = cell_valid[i-1];
      end
      if (i == CAP - 1) begin : g_tail
         assign ok_k = '0;
         assign ov   = '0;
         assign oval = 1'b0;
      end else begin : g_mid
         assign ok_k = cell_key[i+1];
         assign ov   = cell_value[i+1];
         assign oval = cell_valid[i+1];
      end

      assign cell_cmd[i].take_newer  = do_insert;
      assign cell_cmd[i].take_older  = do_erase & chain_ff[i];
      assign cell_cmd[i].write_value = do_write & match_ff[i];

      okvt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cell_cmd[i]),
         .cmp_key     (key_ff),
         .wr_value    (value_ff),
         .newer_key   (nk),
         .newer_value (nv),
         .newer_valid (nval),
         .older_key   (ok_k),
         .older_value (ov),
         .older_valid (oval),
         .hit_in      (cell_hit[i]),
         .key         (cell_key[i]),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .match       (cell_match[i]),
         .hit_out     (cell_hit[i+1])
      );
   end

   // lookup selects the matching slot, position read selects by index
   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         if (op_ff == okvt_pkg::OP_READ) begin
            sel_in[i] = (32'(pos_ff) == i);
         end else begin
            sel_in[i] = cell_match[i];
         end
      end
   end

   always_comb begin
      sel_key   = '0;
      sel_value = '0;
      for (int i = 0; i < CAP; i++) begin
         sel_key   = sel_key   | (cell_key[i]   & {KB{sel_ff[i]}});
         sel_value = sel_value | (cell_value[i] & {VB{sel_ff[i]}});
      end
   end

   // ---------------------------------------------------------------- decision
   assign hit      = |match_ff;
   assign full     = (count_ff == CB'(CAP));
   assign in_range = (32'(pos_ff) < 32'(count_ff));

   always_comb begin
      do_insert = 1'b0;
      do_erase  = 1'b0;
      do_write  = 1'b0;
      ok_in     = 1'b0;
      status_in = okvt_pkg::ST_DONE;
      fk_in     = '0;
      fv_in     = '0;
      count_in  = count_ff;
      case (op_ff)
         okvt_pkg::OP_INSERT, okvt_pkg::OP_UPSERT: begin
            if (hit) begin
               if (op_ff == okvt_pkg::OP_UPSERT) begin
                  do_write = 1'b1;
                  ok_in    = 1'b1;
               end else begin
                  status_in = okvt_pkg::ST_MISMATCH;
               end
            end else if (full) begin
               status_in = okvt_pkg::ST_FULL;
            end else begin
               do_insert = 1'b1;
               ok_in     = 1'b1;
               count_in  = count_ff + CB'(1);
            end
         end
         okvt_pkg::OP_UPDATE: begin
            if (hit) begin
               do_write = 1'b1;
               ok_in    = 1'b1;
            end else begin
               status_in = okvt_pkg::ST_MISMATCH;
            end
         end
         okvt_pkg::OP_ERASE: begin
            if (hit) begin
               do_erase = 1'b1;
               ok_in    = 1'b1;
               count_in = count_ff - CB'(1);
            end else begin
               status_in = okvt_pkg::ST_MISMATCH;
            end
         end
         okvt_pkg::OP_LOOKUP: begin
            if (hit) begin
               ok_in = 1'b1;
               fv_in = sel_value;
            end else begin
               status_in = okvt_pkg::ST_MISMATCH;
            end
         end
         okvt_pkg::OP_READ: begin
            if (in_range) begin
               ok_in = 1'b1;
               fk_in = sel_key;
               fv_in = sel_value;
            end else begin
               status_in = okvt_pkg::ST_RANGE;
            end
         end
         default: begin
         end
      endcase
      if (state_ff != S_APPLY) begin
         do_insert = 1'b0;
         do_erase  = 1'b0;
         do_write  = 1'b0;
         count_in  = count_ff;
      end
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: state_in = S_APPLY;
         S_APPLY:   state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= (state_ff == S_APPLY);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         op_ff    <= req_operation;
         key_ff   <= req_key;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      if (state_ff == S_COMPARE) begin
         match_ff <= cell_match;
         chain_ff <= cell_hit[CAP:1];
         sel_ff   <= sel_in;
      end
      if (state_ff == S_APPLY) begin
         rsp_ok_ff     <= ok_in;
         rsp_status_ff <= status_in;
         rsp_key_ff    <= fk_in;
         rsp_value_ff  <= fv_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_key   = rsp_key_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;

   // ---------------------------------------------------------------- checks
   a_unique_keys: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_match))
      else $error("more than one slot holds the request key");

   a_count_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == 32'(count_ff))
      else $error("entry count disagrees with valid slots");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CAP)
      else $error("entry count above capacity");

   a_strobe_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == S_APPLY)
      else $error("response strobe without an apply cycle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

endmodule
